// File: src/cbspl_pkg.sv
// ----------------------------------------------------------------------------
// cbspl_pkg
// Shared constants, widths and command type for the cubic B-spline evaluator.
// ----------------------------------------------------------------------------
package cbspl_pkg;

  localparam int MAX_POINTS    = 64;
  localparam int SPLINE_DEGREE = 3;
  localparam int ADDR_W        = $clog2(MAX_POINTS);
  localparam int COUNT_W       = 7;
  localparam int FRAC_W        = 12;
  localparam int TINT_W        = 8;
  localparam int T_W           = TINT_W + FRAC_W;
  localparam int COORD_W       = 16;
  localparam int TAN_W         = 17;
  localparam int NUM_COORDS    = 3;
  localparam int DIV_STEPS     = TINT_W;

  // weight and accumulator widths
  localparam int PB_W   = 40;
  localparam int TB_W   = 28;
  localparam int PACC_W = 56;
  localparam int TACC_W = 46;
  localparam int Q_W    = 22;

  localparam logic signed [PB_W-1:0]   ONE_PB = PB_W'(1) <<< (3*FRAC_W);
  localparam logic signed [TB_W-1:0]   ONE_TB = TB_W'(1) <<< (2*FRAC_W);
  localparam logic signed [PACC_W-1:0] HALF_P = PACC_W'(3) <<< (3*FRAC_W);
  localparam logic signed [TACC_W-1:0] HALF_T = TACC_W'(3) <<< (2*FRAC_W);

  // floor divide by 6 through a biased reciprocal multiply
  localparam int DIVY_W = 20;
  localparam int RECIP_SH = 21;
  localparam logic [DIVY_W-1:0]      RECIP     = DIVY_W'(((1 << RECIP_SH) + 1) / 3);
  localparam logic signed [Q_W-1:0]  BIAS      = Q_W'(6 * (1 << 17));
  localparam logic signed [Q_W-1:0]  BIAS_DIV6 = Q_W'(1 << 17);

  localparam logic signed [Q_W-1:0] POS_MAX = Q_W'(32767);
  localparam logic signed [Q_W-1:0] POS_MIN = -Q_W'(32768);
  localparam logic signed [Q_W-1:0] TAN_MAX = Q_W'(65535);
  localparam logic signed [Q_W-1:0] TAN_MIN = -Q_W'(65536);

  localparam logic [1:0] SEL_X = 2'd0;
  localparam logic [1:0] SEL_Y = 2'd1;
  localparam logic [1:0] SEL_Z = 2'd2;

  typedef struct packed {
    logic       store;
    logic       load_eval;
    logic       div_step;
    logic       rd_en;
    logic       mul_en;
    logic       fin_en;
    logic [1:0] sel;
    logic [1:0] k;
  } cbspl_cmd_t;

endpackage

// File: src/cbspl_ctrl.sv
// ----------------------------------------------------------------------------
// cbspl_ctrl
// Sequencer: segment wrap, point reads, multiply-accumulate, rounding, done.
// ----------------------------------------------------------------------------
module cbspl_ctrl import cbspl_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  input  logic       mode,
  output logic       busy,
  output logic       done,
  output cbspl_cmd_t cmd
);

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_DIV   = 7'b0000010,
    S_READ  = 7'b0000100,
    S_MUL   = 7'b0001000,
    S_DRAIN = 7'b0010000,
    S_FIN   = 7'b0100000,
    S_DONE  = 7'b1000000
  } state_t;

  state_t     state, state_next;
  logic [2:0] cnt, cnt_next;
  logic [1:0] k, k_next;
  logic [1:0] c, c_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
      k     <= '0;
      c     <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      k     <= k_next;
      c     <= c_next;
    end
  end

  always_comb begin
    state_next    = state;
    cnt_next      = cnt;
    k_next        = k;
    c_next        = c;
    cmd           = '0;
    cmd.k         = k;
    cmd.sel       = c;
    done          = 1'b0;
    unique case (state)
      S_IDLE: begin
        cmd.store = start & ~mode;
        if (start && mode) begin
          cmd.load_eval = 1'b1;
          cnt_next      = '0;
          state_next    = S_DIV;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        cnt_next     = cnt + 3'd1;
        if (cnt == 3'(DIV_STEPS - 1)) begin
          k_next     = '0;
          state_next = S_READ;
        end
      end
      S_READ: begin
        cmd.rd_en  = 1'b1;
        c_next     = '0;
        state_next = S_MUL;
      end
      S_MUL: begin
        cmd.mul_en = 1'b1;
        if (c == 2'(NUM_COORDS - 1)) begin
          c_next = '0;
          if (k == 2'(SPLINE_DEGREE)) begin
            state_next = S_DRAIN;
          end else begin
            k_next     = k + 2'd1;
            state_next = S_READ;
          end
        end else begin
          c_next = c + 2'd1;
        end
      end
      S_DRAIN: begin
        c_next     = '0;
        state_next = S_FIN;
      end
      S_FIN: begin
        cmd.fin_en = 1'b1;
        if (c == 2'(NUM_COORDS - 1)) begin
          state_next = S_DONE;
        end else begin
          c_next = c + 2'd1;
        end
      end
      S_DONE: begin
        done       = 1'b1;
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  assign busy = (state != S_IDLE);

endmodule

// File: src/cbspl_datapath.sv
// ----------------------------------------------------------------------------
// cbspl_datapath
// Point store, segment divider, basis weights, MAC and rounding units.
// ----------------------------------------------------------------------------
module cbspl_datapath import cbspl_pkg::*; (
  input  logic                      clk,
  input  logic                      rst,
  input  cbspl_cmd_t                cmd,
  input  logic [ADDR_W-1:0]         point_index,
  input  logic signed [COORD_W-1:0] coord_x,
  input  logic signed [COORD_W-1:0] coord_y,
  input  logic signed [COORD_W-1:0] coord_z,
  input  logic [T_W-1:0]            t_value,
  input  logic                      cfg_we,
  input  logic [COUNT_W-1:0]        cfg_data,
  output logic [ADDR_W-1:0]         segment,
  output logic signed [COORD_W-1:0] pos_x,
  output logic signed [COORD_W-1:0] pos_y,
  output logic signed [COORD_W-1:0] pos_z,
  output logic signed [TAN_W-1:0]   tan_x,
  output logic signed [TAN_W-1:0]   tan_y,
  output logic signed [TAN_W-1:0]   tan_z
);

  function automatic logic signed [Q_W-1:0] floor_div6(input logic signed [Q_W-1:0] q);
    logic [Q_W-1:0]          x;
    logic [DIVY_W-1:0]       y;
    logic [2*DIVY_W-1:0]     m;
    x = unsigned'(q + BIAS);
    y = x[DIVY_W:1];
    m = y * RECIP;
    floor_div6 = signed'(Q_W'(m[2*DIVY_W-1:RECIP_SH])) - BIAS_DIV6;
  endfunction

  function automatic logic signed [Q_W-1:0] clip(input logic signed [Q_W-1:0] v,
                                                  input logic signed [Q_W-1:0] lo,
                                                  input logic signed [Q_W-1:0] hi);
    logic signed [Q_W-1:0] r;
    r = v;
    if (v < lo) r = lo;
    if (v > hi) r = hi;
    clip = r;
  endfunction

  // configuration
  logic [COUNT_W-1:0] point_count;
  logic [COUNT_W-1:0] cnt_eff;

  always_ff @(posedge clk) begin
    if (rst) point_count <= COUNT_W'(4);
    else if (cfg_we) point_count <= cfg_data;
  end

  always_comb begin
    cnt_eff = point_count;
    if (point_count < COUNT_W'(SPLINE_DEGREE + 1)) cnt_eff = COUNT_W'(SPLINE_DEGREE + 1);
    if (point_count > COUNT_W'(MAX_POINTS))        cnt_eff = COUNT_W'(MAX_POINTS);
  end

  // point store
  logic [3*COORD_W-1:0] store [MAX_POINTS];
  logic [3*COORD_W-1:0] rd_data;
  logic [ADDR_W-1:0]    rem;

  always_ff @(posedge clk) begin
    if (cmd.store) store[point_index] <= {coord_x, coord_y, coord_z};
    if (cmd.rd_en) rd_data <= store[ADDR_W'(rem + ADDR_W'(cmd.k))];
  end

  // segment wrap, one quotient bit per step
  logic [TINT_W-1:0] dvd;
  logic [ADDR_W-1:0] modulus;
  logic [FRAC_W-1:0] u;
  logic [ADDR_W:0]   trial;

  assign trial = {rem, dvd[TINT_W-1]};

  always_ff @(posedge clk) begin
    if (cmd.load_eval) begin
      rem     <= '0;
      dvd     <= t_value[T_W-1:FRAC_W];
      u       <= t_value[FRAC_W-1:0];
      modulus <= ADDR_W'(cnt_eff - COUNT_W'(SPLINE_DEGREE));
    end else if (cmd.div_step) begin
      dvd <= dvd << 1;
      if (trial >= {1'b0, modulus}) rem <= ADDR_W'(trial - {1'b0, modulus});
      else                          rem <= trial[ADDR_W-1:0];
    end
  end

  // basis weights, registered from u through u2/w2, then u3/w3, then pb/tb
  logic [FRAC_W:0]     w;
  logic [2*FRAC_W-1:0] u2;
  logic [2*FRAC_W+1:0] w2;
  logic [3*FRAC_W-1:0] u3;
  logic [3*FRAC_W+2:0] w3;
  logic signed [PB_W-1:0] pb [4];
  logic signed [TB_W-1:0] tb [4];
  logic signed [PB_W-1:0] u3p, u2p, up, w3p;
  logic signed [TB_W-1:0] u2t, ut, w2t;

  assign w   = (FRAC_W+1)'(1 << FRAC_W) - {1'b0, u};
  assign u3p = signed'(PB_W'(u3));
  assign u2p = signed'(PB_W'(u2));
  assign up  = signed'(PB_W'(u));
  assign w3p = signed'(PB_W'(w3));
  assign u2t = signed'(TB_W'(u2));
  assign ut  = signed'(TB_W'(u));
  assign w2t = signed'(TB_W'(w2));

  always_ff @(posedge clk) begin
    u2 <= u * u;
    w2 <= w * w;
    u3 <= u2 * u;
    w3 <= w2 * w;
    pb[0] <= w3p;
    pb[1] <= 3 * u3p - 6 * (u2p <<< FRAC_W) + 4 * ONE_PB;
    pb[2] <= -3 * u3p + 3 * (u2p <<< FRAC_W) + 3 * (up <<< (2*FRAC_W)) + ONE_PB;
    pb[3] <= u3p;
    tb[0] <= -3 * w2t;
    tb[1] <= 9 * u2t - 12 * (ut <<< FRAC_W);
    tb[2] <= -9 * u2t + 6 * (ut <<< FRAC_W) + 3 * ONE_TB;
    tb[3] <= 3 * u2t;
  end

  // multiply-accumulate
  logic signed [COORD_W-1:0] v;
  logic signed [PACC_W-1:0]  prod_p;
  logic signed [TACC_W-1:0]  prod_t;
  logic                      prod_vld;
  logic [1:0]                prod_sel;
  logic signed [PACC_W-1:0]  acc_p [NUM_COORDS];
  logic signed [TACC_W-1:0]  acc_t [NUM_COORDS];

  always_comb begin
    case (cmd.sel)
      SEL_X:   v = signed'(rd_data[3*COORD_W-1:2*COORD_W]);
      SEL_Y:   v = signed'(rd_data[2*COORD_W-1:COORD_W]);
      default: v = signed'(rd_data[COORD_W-1:0]);
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) prod_vld <= 1'b0;
    else     prod_vld <= cmd.mul_en;
  end

  always_ff @(posedge clk) begin
    prod_sel <= cmd.sel;
    prod_p   <= v * pb[cmd.k];
    prod_t   <= v * tb[cmd.k];
    if (cmd.load_eval) begin
      for (int i = 0; i < NUM_COORDS; i++) begin
        acc_p[i] <= '0;
        acc_t[i] <= '0;
      end
    end else if (prod_vld) begin
      acc_p[prod_sel] <= acc_p[prod_sel] + prod_p;
      acc_t[prod_sel] <= acc_t[prod_sel] + prod_t;
    end
  end

  // round to nearest, saturate
  logic signed [PACC_W-1:0] ap;
  logic signed [TACC_W-1:0] at;
  logic signed [Q_W-1:0]    qp, qt, rp, rt;

  assign ap = acc_p[cmd.sel] + HALF_P;
  assign at = acc_t[cmd.sel] + HALF_T;
  assign qp = Q_W'(ap >>> (3*FRAC_W));
  assign qt = Q_W'(at >>> (2*FRAC_W));
  assign rp = clip(floor_div6(qp), POS_MIN, POS_MAX);
  assign rt = clip(floor_div6(qt), TAN_MIN, TAN_MAX);

  always_ff @(posedge clk) begin
    if (cmd.fin_en) begin
      segment <= rem;
      case (cmd.sel)
        SEL_X: begin
          pos_x <= COORD_W'(rp);
          tan_x <= TAN_W'(rt);
        end
        SEL_Y: begin
          pos_y <= COORD_W'(rp);
          tan_y <= TAN_W'(rt);
        end
        default: begin
          pos_z <= COORD_W'(rp);
          tan_z <= TAN_W'(rt);
        end
      endcase
    end
  end

endmodule

// File: src/cubic_bspline_point_and_tangent.sv
// ----------------------------------------------------------------------------
// cubic_bspline_point_and_tangent
// Uniform cubic B-spline point and tangent evaluator, Q8.8 coordinates.
// ----------------------------------------------------------------------------
// A transfer is taken when start is high and busy is low. A load (mode 0)
// writes one control point in that cycle and leaves busy low, so loads can
// come every cycle. An evaluate (mode 1) holds busy through the bit-serial
// wrap of t by (point_count - 3), with point_count clamped to 4..64, then one
// store read per point followed by one pass per axis through the shared
// position and tangent multipliers, then accumulate, rounding and saturation,
// then done. Results appear with a one-cycle done pulse in the last busy cycle
// and must be captured then; the receiver cannot stall. The user must write
// point_count only while busy is low; the block itself does not enforce it.
module cubic_bspline_point_and_tangent import cbspl_pkg::*; (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  output logic                      busy,
  input  logic                      mode,
  input  logic [ADDR_W-1:0]         point_index,
  input  logic signed [COORD_W-1:0] coord_x,
  input  logic signed [COORD_W-1:0] coord_y,
  input  logic signed [COORD_W-1:0] coord_z,
  input  logic [T_W-1:0]            t_value,
  input  logic                      cfg_we,
  input  logic [COUNT_W-1:0]        cfg_data,
  output logic                      done,
  output logic [ADDR_W-1:0]         segment,
  output logic signed [COORD_W-1:0] pos_x,
  output logic signed [COORD_W-1:0] pos_y,
  output logic signed [COORD_W-1:0] pos_z,
  output logic signed [TAN_W-1:0]   tan_x,
  output logic signed [TAN_W-1:0]   tan_y,
  output logic signed [TAN_W-1:0]   tan_z
);

  cbspl_cmd_t cmd;

  cbspl_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .mode  (mode),
    .busy  (busy),
    .done  (done),
    .cmd   (cmd)
  );

  cbspl_datapath u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .point_index (point_index),
    .coord_x     (coord_x),
    .coord_y     (coord_y),
    .coord_z     (coord_z),
    .t_value     (t_value),
    .cfg_we      (cfg_we),
    .cfg_data    (cfg_data),
    .segment     (segment),
    .pos_x       (pos_x),
    .pos_y       (pos_y),
    .pos_z       (pos_z),
    .tan_x       (tan_x),
    .tan_y       (tan_y),
    .tan_z       (tan_z)
  );

endmodule

// File: src/cbspl_checker.sv
// ----------------------------------------------------------------------------
// cbspl_checker
// Port-level checks on transfer and busy/done sequencing.
// ----------------------------------------------------------------------------
module cbspl_checker import cbspl_pkg::*; (
  input logic              clk,
  input logic              rst,
  input logic              start,
  input logic              busy,
  input logic              mode,
  input logic              done,
  input logic [ADDR_W-1:0] segment
);

  a_load_no_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && !mode) |=> !busy)
    else $error("load transfer raised busy");

  a_eval_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && mode) |=> busy)
    else $error("evaluate transfer did not raise busy");

  a_done_in_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> (busy && segment <= ADDR_W'(MAX_POINTS - SPLINE_DEGREE - 1)))
    else $error("done outside busy or segment out of range");

  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    done |=> (!done && !busy))
    else $error("done not a single pulse ending busy");

endmodule

bind cubic_bspline_point_and_tangent cbspl_checker u_chk (.*);

// File: dv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Checks the cubic B-spline point and tangent evaluator. Loads and evaluates
// are sent with random gaps under several point counts, and every done pulse
// is compared, field by field, with an exact integer prediction of the curve.
// ----------------------------------------------------------------------------
import cbspl_pkg::*;

typedef struct {
  logic [ADDR_W-1:0]         seg;
  logic signed [COORD_W-1:0] px, py, pz;
  logic signed [TAN_W-1:0]   tx, ty, tz;
} curve_point_t;

class bspline_predictor;
  longint              ctrl [MAX_POINTS][NUM_COORDS];
  logic [COUNT_W-1:0]  count_reg = 4;
  curve_point_t        pending_points[$];
  int                  mismatches = 0;

  function longint round_div(longint num, longint den);
    longint n2, d2, q;
    n2 = 2 * num + den;
    d2 = 2 * den;
    q = n2 / d2;
    if ((n2 % d2) != 0 && n2 < 0) q = q - 1;
    return q;
  endfunction

  function longint sat(longint v, longint lo, longint hi);
    return (v < lo) ? lo : (v > hi) ? hi : v;
  endfunction

  function void note_transfer(logic md, logic [ADDR_W-1:0] idx,
                              logic signed [COORD_W-1:0] cx, cy, cz,
                              logic [T_W-1:0] tv);
    longint s, u, w, cnt, seg, pn, tn, v;
    longint pb[4], tb[4];
    longint p[3], t[3];
    curve_point_t r;
    if (!md) begin
      ctrl[idx][0] = cx;
      ctrl[idx][1] = cy;
      ctrl[idx][2] = cz;
      return;
    end
    s = 1 << FRAC_W;
    cnt = count_reg;
    if (cnt < 4) cnt = 4;
    if (cnt > MAX_POINTS) cnt = MAX_POINTS;
    seg = (tv >> FRAC_W) % (cnt - SPLINE_DEGREE);
    u = tv & (s - 1);
    w = s - u;
    pb[0] = w * w * w;
    pb[1] = 3 * u * u * u - 6 * u * u * s + 4 * s * s * s;
    pb[2] = -3 * u * u * u + 3 * u * u * s + 3 * u * s * s + s * s * s;
    pb[3] = u * u * u;
    tb[0] = -3 * w * w;
    tb[1] = 9 * u * u - 12 * u * s;
    tb[2] = -9 * u * u + 6 * u * s + 3 * s * s;
    tb[3] = 3 * u * u;
    for (int c = 0; c < NUM_COORDS; c++) begin
      pn = 0;
      tn = 0;
      for (int k = 0; k < 4; k++) begin
        v = ctrl[(seg + k) % MAX_POINTS][c];
        pn += v * pb[k];
        tn += v * tb[k];
      end
      p[c] = sat(round_div(pn, 6 * s * s * s), -32768, 32767);
      t[c] = sat(round_div(tn, 6 * s * s), -65536, 65535);
    end
    r.seg = ADDR_W'(seg);
    r.px = COORD_W'(p[0]); r.py = COORD_W'(p[1]); r.pz = COORD_W'(p[2]);
    r.tx = TAN_W'(t[0]); r.ty = TAN_W'(t[1]); r.tz = TAN_W'(t[2]);
    pending_points.push_back(r);
  endfunction

  function void check_result(curve_point_t a);
    curve_point_t e;
    if (pending_points.size() == 0) begin
      $error("result with nothing expected: segment %0d", a.seg);
      mismatches++;
      return;
    end
    e = pending_points.pop_front();
    if (a.seg !== e.seg) begin
      $error("segment: expected %0d actual %0d", e.seg, a.seg); mismatches++;
    end
    if (a.px !== e.px) begin
      $error("pos_x: expected %0d actual %0d", e.px, a.px); mismatches++;
    end
    if (a.py !== e.py) begin
      $error("pos_y: expected %0d actual %0d", e.py, a.py); mismatches++;
    end
    if (a.pz !== e.pz) begin
      $error("pos_z: expected %0d actual %0d", e.pz, a.pz); mismatches++;
    end
    if (a.tx !== e.tx) begin
      $error("tan_x: expected %0d actual %0d", e.tx, a.tx); mismatches++;
    end
    if (a.ty !== e.ty) begin
      $error("tan_y: expected %0d actual %0d", e.ty, a.ty); mismatches++;
    end
    if (a.tz !== e.tz) begin
      $error("tan_z: expected %0d actual %0d", e.tz, a.tz); mismatches++;
    end
  endfunction
endclass

module testbench;
  logic                      clk = 0;
  logic                      rst = 1;
  logic                      start = 0;
  logic                      busy;
  logic                      mode = 0;
  logic [ADDR_W-1:0]         point_index = 0;
  logic signed [COORD_W-1:0] coord_x = 0, coord_y = 0, coord_z = 0;
  logic [T_W-1:0]            t_value = 0;
  logic                      cfg_we = 0;
  logic [COUNT_W-1:0]        cfg_data = 0;
  logic                      done;
  logic [ADDR_W-1:0]         segment;
  logic signed [COORD_W-1:0] pos_x, pos_y, pos_z;
  logic signed [TAN_W-1:0]   tan_x, tan_y, tan_z;

  bspline_predictor model = new();

  cubic_bspline_point_and_tangent dut (.*);

  always begin
    #4 clk = 1;
    #4 clk = 0;
  end

  always @(posedge clk) begin
    curve_point_t r;
    if (!rst && done) begin
      r.seg = segment;
      r.px = pos_x; r.py = pos_y; r.pz = pos_z;
      r.tx = tan_x; r.ty = tan_y; r.tz = tan_z;
      model.check_result(r);
    end
  end

  task automatic send(logic md, logic [ADDR_W-1:0] idx,
                      logic signed [COORD_W-1:0] cx, cy, cz, logic [T_W-1:0] tv);
    int gap;
    gap = $urandom_range(0, 3);
    if ($urandom_range(0, 3) == 0) gap = 0;
    start <= 1;
    mode <= md;
    point_index <= idx;
    coord_x <= cx;
    coord_y <= cy;
    coord_z <= cz;
    t_value <= tv;
    @(posedge clk);
    while (busy) @(posedge clk);
    model.note_transfer(md, idx, cx, cy, cz, tv);
    if (gap > 0) begin
      start <= 0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic load(logic [ADDR_W-1:0] idx, logic signed [COORD_W-1:0] cx, cy, cz);
    send(1'b0, idx, cx, cy, cz, T_W'($urandom));
  endtask

  task automatic evaluate(logic [T_W-1:0] tv);
    send(1'b1, ADDR_W'($urandom), COORD_W'($urandom), COORD_W'($urandom),
         COORD_W'($urandom), tv);
  endtask

  task automatic drain();
    start <= 0;
    @(posedge clk);
    while (model.pending_points.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_count(logic [COUNT_W-1:0] val);
    drain();
    cfg_we <= 1;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 0;
    model.count_reg = val;
  endtask

  task automatic random_item();
    int kind;
    kind = $urandom_range(0, 9);
    if (kind < 4) load(ADDR_W'($urandom), COORD_W'($urandom), COORD_W'($urandom),
                       COORD_W'($urandom));
    else if (kind < 5) load(ADDR_W'($urandom),
                            $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000,
                            COORD_W'($urandom),
                            $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000);
    else if (kind < 8) evaluate(T_W'($urandom_range(0, 70 << FRAC_W)));
    else evaluate(T_W'($urandom));
  endtask

  initial begin
    logic [COUNT_W-1:0] counts[8];
    counts = '{7'd4, 7'd64, 7'd0, 7'd127, 7'd5, 7'd33, 7'd3, 7'd65};
    repeat (4) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    for (int i = 0; i < MAX_POINTS; i++)
      load(ADDR_W'(i), COORD_W'($urandom), COORD_W'($urandom), COORD_W'($urandom));
    load(6'd0, 16'sh7fff, 16'sh7fff, 16'sh8000);
    load(6'd1, 16'sh7fff, 16'sh8000, 16'sh8000);
    load(6'd2, 16'sh7fff, 16'sh7fff, 16'sh8000);
    load(6'd3, 16'sh7fff, 16'sh8000, 16'sh8000);
    evaluate(20'h00000);
    evaluate(20'h00fff);
    evaluate(20'h00800);
    evaluate(20'hfffff);
    evaluate(20'h01000);
    write_count(7'd64);
    evaluate(20'hfffff);
    evaluate(20'h3c000);
    evaluate(20'h3cfff);
    load(6'd63, 16'sh8000, 16'sh7fff, 16'sh7fff);
    evaluate(20'h3c7ff);
    for (int ph = 0; ph < 8; ph++) begin
      write_count(ph < 7 ? counts[ph] : COUNT_W'($urandom));
      repeat (200) random_item();
    end
    write_count(COUNT_W'($urandom));
    repeat (20) random_item();
    drain();
    if (model.mismatches == 0 && model.pending_points.size() == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

  initial begin
    #20ms;
    $display("CHECK FAILED");
    $finish;
  end
endmodule
